// ----- rtl/core/rqcs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqcs_pkg
// Shared widths, register codes and reset values for the requantizing
// channel shuffle.
// ----------------------------------------------------------------------------
package rqcs_pkg;

  localparam int unsigned ChanW   = 12;
  localparam int unsigned ValW    = 8;
  localparam int unsigned BiasW   = 9;
  localparam int unsigned GainW   = 24;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 24;
  localparam int unsigned FracW   = 16;
  localparam int unsigned ProdW   = (BiasW) + GainW;

  localparam logic [GainW-1:0] GainReset = GainW'(65536);
  localparam logic [ValW-1:0]  ValMax    = {ValW{1'b1}};

  typedef enum logic [CfgIdxW-1:0] {
    REG_BIAS_A       = 3'd0,
    REG_BIAS_B       = 3'd1,
    REG_GAIN_A       = 3'd2,
    REG_GAIN_B       = 3'd3,
    REG_OUT_ZERO     = 3'd4,
    REG_SHUFFLE_MODE = 3'd5,
    REG_HALF_SPLIT   = 3'd6
  } rqcs_reg_e;

  typedef enum logic {
    SHUF_SPLIT      = 1'b0,
    SHUF_INTERLEAVE = 1'b1
  } rqcs_shuf_e;

endpackage

// ----- rtl/core/rqcs_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqcs_in_if
// Element input channel: source tensor, channel and uint8 value.
// ----------------------------------------------------------------------------
interface rqcs_in_if
  import rqcs_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             source_sel;
  logic [ChanW-1:0] in_channel;
  logic [ValW-1:0]  in_value;

  modport source (output valid, source_sel, in_channel, in_value, input ready);
  modport sink   (input valid, source_sel, in_channel, in_value, output ready);
endinterface

// ----- rtl/core/rqcs_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqcs_out_if
// Result channel: destination tensor, channel and requantized value.
// ----------------------------------------------------------------------------
interface rqcs_out_if
  import rqcs_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             dest_sel;
  logic [ChanW-1:0] dest_channel;
  logic [ValW-1:0]  out_value;

  modport source (output valid, dest_sel, dest_channel, out_value, input ready);
  modport sink   (input valid, dest_sel, dest_channel, out_value, output ready);
endinterface

// ----- rtl/core/rqcs_cfg_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqcs_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface rqcs_cfg_if
  import rqcs_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgDatW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/requantize_channel_shuffle.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// requantize_channel_shuffle
// Requantizes uint8 elements of two source tensors and maps each element's
// channel to a destination tensor and channel.
// ----------------------------------------------------------------------------
// Three-stage pipeline that takes one element and delivers one result per
// cycle while the output keeps accepting results (no backpressure). Stage
// one registers the element, stage two adds the source bias, takes the
// magnitude, multiplies it by the 24-bit gain (9x24 multiplier) and computes
// the destination channel, stage three rounds half away from zero, applies
// the output zero point and clamps to 0..255. Each stage moves on when the
// stage after it is empty or moving, so output backpressure stalls the
// pipeline without bubbles. Register writes are always accepted and take
// effect at once; write them only while no element is in flight.
module requantize_channel_shuffle
  import rqcs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  rqcs_cfg_if.sink   cfg_i,
  rqcs_in_if.sink    in_i,
  rqcs_out_if.source out_o
);

  // configuration registers
  logic signed [BiasW-1:0] bias_a_q, bias_b_q;
  logic [GainW-1:0]        gain_a_q, gain_b_q;
  logic [ValW-1:0]         out_zero_q;
  rqcs_shuf_e              shuffle_mode_q;
  logic [ChanW-1:0]        half_split_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_a_q       <= '0;
      bias_b_q       <= '0;
      gain_a_q       <= GainReset;
      gain_b_q       <= GainReset;
      out_zero_q     <= '0;
      shuffle_mode_q <= SHUF_SPLIT;
      half_split_q   <= '0;
    end else if (cfg_i.valid) begin
      unique case (rqcs_reg_e'(cfg_i.index))
        REG_BIAS_A:       bias_a_q       <= cfg_i.data[BiasW-1:0];
        REG_BIAS_B:       bias_b_q       <= cfg_i.data[BiasW-1:0];
        REG_GAIN_A:       gain_a_q       <= cfg_i.data[GainW-1:0];
        REG_GAIN_B:       gain_b_q       <= cfg_i.data[GainW-1:0];
        REG_OUT_ZERO:     out_zero_q     <= cfg_i.data[ValW-1:0];
        REG_SHUFFLE_MODE: shuffle_mode_q <= rqcs_shuf_e'(cfg_i.data[0]);
        REG_HALF_SPLIT:   half_split_q   <= cfg_i.data[ChanW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic a_valid_q, b_valid_q, c_valid_q;
  logic a_ready, b_ready, c_ready;

  assign c_ready    = !c_valid_q || out_o.ready;
  assign b_ready    = !b_valid_q || c_ready;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_i.ready = a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q <= in_i.valid;
      if (b_ready) b_valid_q <= a_valid_q;
      if (c_ready) c_valid_q <= b_valid_q;
    end
  end

  // stage one: input register
  logic             a_sel_q;
  logic [ChanW-1:0] a_ch_q;
  logic [ValW-1:0]  a_val_q;

  always_ff @(posedge clk_i) begin
    if (a_ready && in_i.valid) begin
      a_sel_q <= in_i.source_sel;
      a_ch_q  <= in_i.in_channel;
      a_val_q <= in_i.in_value;
    end
  end

  // stage two: bias, magnitude, multiply, channel mapping
  logic signed [BiasW-1:0] bias_sel;
  logic [GainW-1:0]        gain_sel;
  logic signed [BiasW:0]   b_sum;
  logic [BiasW:0]          b_abs;
  logic [ProdW-1:0]        b_prod_d;
  logic                    b_neg_d;
  logic [ChanW-1:0]        ch_diff;
  logic                    b_dsel_d;
  logic [ChanW-1:0]        b_dch_d;

  always_comb begin
    bias_sel = a_sel_q ? bias_b_q : bias_a_q;
    gain_sel = a_sel_q ? gain_b_q : gain_a_q;
    b_sum    = $signed({2'b00, a_val_q}) + $signed({bias_sel[BiasW-1], bias_sel});
    b_neg_d  = b_sum[BiasW];
    b_abs    = b_neg_d ? (BiasW+1)'(-b_sum) : b_sum;
    // magnitude is at most 510, so it fits the bias width unsigned
    b_prod_d = ProdW'(b_abs[BiasW-1:0]) * ProdW'(gain_sel);

    ch_diff = a_ch_q - half_split_q;
    if (shuffle_mode_q == SHUF_SPLIT) begin
      b_dsel_d = a_ch_q[0];
      b_dch_d  = (a_ch_q >> 1) + (a_sel_q ? half_split_q : '0);
    end else if (a_ch_q < half_split_q) begin
      b_dsel_d = 1'b0;
      b_dch_d  = {a_ch_q[ChanW-2:0], a_sel_q};
    end else begin
      b_dsel_d = 1'b1;
      b_dch_d  = {ch_diff[ChanW-2:0], a_sel_q};
    end
  end

  logic [ProdW-1:0] b_prod_q;
  logic             b_neg_q;
  logic             b_dsel_q;
  logic [ChanW-1:0] b_dch_q;

  always_ff @(posedge clk_i) begin
    if (b_ready && a_valid_q) begin
      b_prod_q <= b_prod_d;
      b_neg_q  <= b_neg_d;
      b_dsel_q <= b_dsel_d;
      b_dch_q  <= b_dch_d;
    end
  end

  // stage three: round, zero point, clamp
  localparam int unsigned RndW = ProdW + 1;
  localparam int unsigned MagW = RndW - FracW;

  logic [RndW-1:0] rnd;
  logic [MagW-1:0] rmag;
  logic [MagW:0]   pos_sum;
  logic [ValW-1:0] c_val_d;

  always_comb begin
    rnd     = RndW'(b_prod_q) + RndW'(1 << (FracW - 1));
    rmag    = rnd[RndW-1:FracW];
    pos_sum = (MagW+1)'(out_zero_q) + (MagW+1)'(rmag);
    if (b_neg_q) begin
      if (rmag > MagW'(out_zero_q)) c_val_d = '0;
      else                          c_val_d = out_zero_q - rmag[ValW-1:0];
    end else begin
      if (pos_sum > (MagW+1)'(ValMax)) c_val_d = ValMax;
      else                             c_val_d = pos_sum[ValW-1:0];
    end
  end

  logic             c_dsel_q;
  logic [ChanW-1:0] c_dch_q;
  logic [ValW-1:0]  c_val_q;

  always_ff @(posedge clk_i) begin
    if (c_ready && b_valid_q) begin
      c_dsel_q <= b_dsel_q;
      c_dch_q  <= b_dch_q;
      c_val_q  <= c_val_d;
    end
  end

  assign out_o.valid        = c_valid_q;
  assign out_o.dest_sel     = c_dsel_q;
  assign out_o.dest_channel = c_dch_q;
  assign out_o.out_value    = c_val_q;

`ifndef NO_ASSERTIONS
  // an empty output stage never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !c_valid_q |-> in_i.ready)
    else $error("input stalled with empty output stage");

  // an input transfer always lands in stage one
  a_input_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> a_valid_q)
    else $error("accepted element lost at stage one");

  // split mode routes by channel parity
  a_split_parity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_ready && a_valid_q && shuffle_mode_q == SHUF_SPLIT
      |=> b_dsel_q == $past(a_ch_q[0]))
    else $error("split mode destination does not follow channel parity");

  // a negative biased value never rises above the zero point
  a_neg_below_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_ready && b_valid_q && b_neg_q |=> c_val_q <= $past(out_zero_q))
    else $error("negative value requantized above zero point");
`endif

endmodule

// ----- bench/rqcs_result_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqcs_result_checker
// Watches the register, element and result channels of the requantizing
// channel shuffle. It keeps its own copy of the registers, predicts the
// destination and requantized value of every element taken in, and compares
// each result with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module rqcs_result_checker
  import rqcs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  rqcs_cfg_if         cfg_mon,
  rqcs_in_if          elem_mon,
  rqcs_out_if         res_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic             dest_sel;
    logic [ChanW-1:0] dest_channel;
    logic [ValW-1:0]  out_value;
  } shuffled_elem_t;

  logic signed [BiasW-1:0] bias_a, bias_b;
  logic [GainW-1:0]        gain_a, gain_b;
  logic [ValW-1:0]         out_zero;
  rqcs_shuf_e              shuf_mode;
  logic [ChanW-1:0]        half_split;

  shuffled_elem_t predicted_q[$];
  shuffled_elem_t oldest;

  function automatic shuffled_elem_t predict_element(input logic             src,
                                                     input logic [ChanW-1:0] chan,
                                                     input logic [ValW-1:0]  val);
    shuffled_elem_t          res;
    logic signed [BiasW-1:0] bias;
    logic [GainW-1:0]        gain;
    int                      biased;
    longint unsigned         mag;
    longint unsigned         rounded;
    longint                  level;
    int unsigned             dest;
    bias = src ? bias_b : bias_a;
    gain = src ? gain_b : gain_a;
    biased = int'(val) + int'(bias);
    mag = (biased < 0) ? longint'(-biased) : longint'(biased);
    // magnitude rounds half away from zero, sign applied afterwards
    rounded = (mag * gain + 64'd32768) >> FracW;
    if (biased < 0) begin
      level = longint'(out_zero) - longint'(rounded);
    end else begin
      level = longint'(out_zero) + longint'(rounded);
    end
    if (level < 0) level = 0;
    if (level > 255) level = 255;
    res.out_value = level[ValW-1:0];
    if (shuf_mode == SHUF_SPLIT) begin
      res.dest_sel = chan[0];
      dest = int'(chan >> 1);
      if (src) dest = dest + int'(half_split);
    end else if (chan < half_split) begin
      res.dest_sel = 1'b0;
      dest = 2 * int'(chan) + int'(src);
    end else begin
      res.dest_sel = 1'b1;
      dest = 2 * (int'(chan) - int'(half_split)) + int'(src);
    end
    // wraps modulo the channel count
    res.dest_channel = dest[ChanW-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_a       = '0;
      bias_b       = '0;
      gain_a       = GainReset;
      gain_b       = GainReset;
      out_zero     = '0;
      shuf_mode    = SHUF_SPLIT;
      half_split   = '0;
      predicted_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // a result never leaves in the cycle its element is taken in, so pop first
      if (res_mon.valid && res_mon.ready) begin
        if (predicted_q.size() == 0) begin
          fail_count_o = fail_count_o + 1;
          $display("%0t: unexpected result sel=%0d ch=%0d val=%0d", $time,
                   res_mon.dest_sel, res_mon.dest_channel, res_mon.out_value);
        end else begin
          oldest = predicted_q.pop_front();
          if (res_mon.dest_sel !== oldest.dest_sel ||
              res_mon.dest_channel !== oldest.dest_channel ||
              res_mon.out_value !== oldest.out_value) begin
            fail_count_o = fail_count_o + 1;
            $display("%0t: mismatch expected sel=%0d ch=%0d val=%0d, got sel=%0d ch=%0d val=%0d",
                     $time, oldest.dest_sel, oldest.dest_channel, oldest.out_value,
                     res_mon.dest_sel, res_mon.dest_channel, res_mon.out_value);
          end
        end
      end
      if (elem_mon.valid && elem_mon.ready) begin
        predicted_q.push_back(predict_element(elem_mon.source_sel, elem_mon.in_channel,
                                              elem_mon.in_value));
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_BIAS_A:       bias_a = cfg_mon.data[BiasW-1:0];
          REG_BIAS_B:       bias_b = cfg_mon.data[BiasW-1:0];
          REG_GAIN_A:       gain_a = cfg_mon.data[GainW-1:0];
          REG_GAIN_B:       gain_b = cfg_mon.data[GainW-1:0];
          REG_OUT_ZERO:     out_zero = cfg_mon.data[ValW-1:0];
          REG_SHUFFLE_MODE: shuf_mode = rqcs_shuf_e'(cfg_mon.data[0]);
          REG_HALF_SPLIT:   half_split = cfg_mon.data[ChanW-1:0];
          default: ;
        endcase
      end
      pending_o = predicted_q.size();
    end
  end

endmodule

// ----- bench/tb_requantize_channel_shuffle.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_requantize_channel_shuffle
// Drives register writes and element streams into the requantizing channel
// shuffle with random gaps on both sides; the checker beside the block
// predicts every result and counts mismatches for the final verdict.
// ----------------------------------------------------------------------------
module tb_requantize_channel_shuffle;
  import rqcs_pkg::*;

  localparam logic [CfgIdxW-1:0] RegUnmapped = 3'd7;
  localparam int unsigned        NumPhases   = 12;
  localparam int unsigned        PhaseElems  = 160;

  logic        clk;
  logic        rst_n;
  bit          quiet;
  logic [11:0] cur_half;
  int unsigned fail_count;
  int unsigned pending;

  rqcs_cfg_if cfg_bus ();
  rqcs_in_if  elem_bus ();
  rqcs_out_if res_bus ();

  requantize_channel_shuffle u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_bus),
    .in_i   (elem_bus),
    .out_o  (res_bus)
  );

  rqcs_result_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_mon      (cfg_bus),
    .elem_mon     (elem_bus),
    .res_mon      (res_bus),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #10ms;
    $display("status: fail");
    $finish;
  end

  function automatic int unsigned draw_gap();
    return quiet ? 0 : $urandom_range(0, 16);
  endfunction

  // tasks start at a rising edge and return at the edge of the transfer
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] data);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      cfg_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
  endtask

  task automatic send_element(input logic src, input logic [ChanW-1:0] chan,
                              input logic [ValW-1:0] val);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      elem_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    elem_bus.valid      <= 1'b1;
    elem_bus.source_sel <= src;
    elem_bus.in_channel <= chan;
    elem_bus.in_value   <= val;
    @(posedge clk);
    while (!elem_bus.ready) @(posedge clk);
  endtask

  // the checker counts the last transfer only once its edge has settled
  task automatic wait_drained();
    elem_bus.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // upper data bits are junk the block must ignore
  task automatic apply_config(input logic [BiasW-1:0] ba, input logic [BiasW-1:0] bb,
                              input logic [GainW-1:0] ga, input logic [GainW-1:0] gb,
                              input logic [ValW-1:0] oz, input logic mode,
                              input logic [ChanW-1:0] hs);
    logic [CfgDatW-1:0] junk;
    junk = CfgDatW'($urandom());
    write_reg(REG_BIAS_A, {junk[CfgDatW-1:BiasW], ba});
    write_reg(REG_GAIN_A, ga);
    write_reg(REG_BIAS_B, {~junk[CfgDatW-1:BiasW], bb});
    write_reg(REG_GAIN_B, gb);
    write_reg(REG_OUT_ZERO, {junk[CfgDatW-1:ValW], oz});
    write_reg(REG_SHUFFLE_MODE, {junk[CfgDatW-1:1], mode});
    write_reg(REG_HALF_SPLIT, {junk[CfgDatW-1:ChanW], hs});
    if ($urandom_range(0, 3) == 0) write_reg(RegUnmapped, CfgDatW'($urandom()));
    cfg_bus.valid <= 1'b0;
    cur_half = hs;
  endtask

  task automatic random_phase();
    logic [BiasW-1:0]  ba, bb;
    logic [GainW-1:0]  ga, gb;
    logic [ValW-1:0]   oz;
    logic [ChanW-1:0]  hs;
    logic [ChanW-1:0]  chan;
    logic [ValW-1:0]   val;
    int                near;
    if ($urandom_range(0, 3) == 0) begin
      ba = $urandom_range(0, 1) ? 9'h100 : 9'h0ff;
      bb = $urandom_range(0, 1) ? 9'h100 : 9'h0ff;
      ga = $urandom_range(0, 1) ? 24'hffffff : 24'h0;
      gb = $urandom_range(0, 1) ? 24'hffffff : 24'h0;
      oz = $urandom_range(0, 1) ? 8'hff : 8'h00;
      hs = $urandom_range(0, 1) ? 12'd2048 : 12'd0;
    end else begin
      ba = BiasW'($urandom());
      bb = BiasW'($urandom());
      ga = ($urandom_range(0, 4) == 0) ? 24'($urandom()) : 24'($urandom_range(0, 24'h3ffff));
      gb = ($urandom_range(0, 4) == 0) ? 24'($urandom()) : 24'($urandom_range(0, 24'h3ffff));
      oz = ValW'($urandom());
      hs = ($urandom_range(0, 5) == 0) ? 12'($urandom()) : 12'($urandom_range(0, 2048));
    end
    apply_config(ba, bb, ga, gb, oz, 1'($urandom_range(0, 1)), hs);
    for (int i = 0; i < PhaseElems; i++) begin
      if (i % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0) begin
        // channels around the split point
        near = int'(cur_half) + int'($urandom_range(0, 4)) - 2;
        if (near < 0) near = 0;
        if (near > 4095) near = 4095;
        chan = near[ChanW-1:0];
      end else begin
        chan = ChanW'($urandom());
      end
      case ($urandom_range(0, 7))
        0:       val = 8'h00;
        1:       val = 8'hff;
        default: val = ValW'($urandom());
      endcase
      send_element(1'($urandom_range(0, 1)), chan, val);
    end
    quiet = 1'b0;
    wait_drained();
  endtask

  // result side stalls independently of the element side
  initial begin
    int unsigned gap;
    res_bus.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        res_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_bus.ready <= 1'b1;
      @(posedge clk);
      while (!res_bus.valid) @(posedge clk);
    end
  end

  initial begin
    quiet    = 1'b0;
    cur_half = '0;
    rst_n    = 1'b0;
    cfg_bus.valid       <= 1'b0;
    cfg_bus.index       <= '0;
    cfg_bus.data        <= '0;
    elem_bus.valid      <= 1'b0;
    elem_bus.source_sel <= 1'b0;
    elem_bus.in_channel <= '0;
    elem_bus.in_value   <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: split mode, unit gain, no bias
    send_element(1'b0, 12'd0, 8'd0);
    send_element(1'b1, 12'd4095, 8'd255);
    send_element(1'b0, 12'd1, 8'd128);
    send_element(1'b1, 12'd2, 8'd1);
    wait_drained();

    // most negative bias, full-scale and zero gain, wrap in interleave mode
    apply_config(9'h100, 9'h0ff, 24'hffffff, 24'h0, 8'hff, SHUF_INTERLEAVE, 12'd0);
    write_reg(RegUnmapped, 24'hffffff);
    cfg_bus.valid <= 1'b0;
    send_element(1'b0, 12'd0, 8'd0);
    send_element(1'b0, 12'd0, 8'd255);
    send_element(1'b1, 12'd4095, 8'd0);
    send_element(1'b1, 12'd4095, 8'd255);
    send_element(1'b0, 12'd4095, 8'd128);
    wait_drained();

    // half-way rounding on both signs around the split point
    apply_config(9'h1ff, 9'h001, 24'h008000, 24'h018000, 8'd128, SHUF_INTERLEAVE,
                 12'd2048);
    send_element(1'b0, 12'd2047, 8'd0);
    send_element(1'b1, 12'd2047, 8'd2);
    send_element(1'b0, 12'd2048, 8'd2);
    send_element(1'b1, 12'd4095, 8'd255);
    send_element(1'b0, 12'd0, 8'd1);
    wait_drained();

    // split mode with the largest split point overflows source 1 channels
    apply_config(9'h000, 9'h000, 24'h010000, 24'h00ffff, 8'd0, SHUF_SPLIT, 12'd4095);
    send_element(1'b1, 12'd4095, 8'd200);
    send_element(1'b1, 12'd4094, 8'd7);
    send_element(1'b0, 12'd4095, 8'd99);
    wait_drained();

    for (int p = 0; p < NumPhases; p++) random_phase();

    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
